// File: hw/rtl/bsq_pkg.sv
// Shared types and constants of the bounded stack/queue engine.
package bsq_pkg;

    // Default sizes of the entry store
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Field widths on the stream ports
    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LIST = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SWAP = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADARG     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PEEK_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd5;

    // One result item from the controller to the output stage
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic                has_value;
        logic [STATUS_W-1:0] status;
        logic                last;
    } rsp_t;

endpackage

// File: hw/rtl/bsq_mem.sv
// Entry store: one write port, two registered read ports.
module bsq_mem #(
    parameter int DEPTH      = bsq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsq_pkg::DATA_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr0,
    input  logic [$clog2(DEPTH)-1:0] rd_addr1,
    output logic [DATA_WIDTH-1:0]    rd_data0,
    output logic [DATA_WIDTH-1:0]    rd_data1
);
    import bsq_pkg::*;

    logic [DATA_WIDTH-1:0] entry_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data0_reg;
    logic [DATA_WIDTH-1:0] rd_data1_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    // Read ports; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data0_reg <= entry_mem[rd_addr0];
            rd_data1_reg <= entry_mem[rd_addr1];
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

// File: hw/rtl/bsq_ctrl.sv
// Command sequencer: pointers, count, mode register and store accesses.
module bsq_ctrl #(
    parameter int DEPTH      = bsq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bsq_pkg::CMD_W-1:0]     cmd,
    input  logic [bsq_pkg::VALUE_W-1:0]   push_value,
    input  logic                          value_valid,
    input  logic                          out_space,
    output logic                          rsp_load,
    output bsq_pkg::rsp_t                 rsp,
    output logic                          mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
    output logic [DATA_WIDTH-1:0]         mem_wr_data,
    output logic                          mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]      mem_rd_addr0,
    output logic [$clog2(DEPTH)-1:0]      mem_rd_addr1,
    input  logic [DATA_WIDTH-1:0]         mem_rd_data0,
    input  logic [DATA_WIDTH-1:0]         mem_rd_data1
);
    import bsq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RESP  = 3'd1;
    localparam logic [2:0] S_LIST  = 3'd2;
    localparam logic [2:0] S_SWAP1 = 3'd3;
    localparam logic [2:0] S_SWAP2 = 3'd4;

    logic [2:0]          state_reg,      state_next;
    logic [PTR_W-1:0]    top_reg,        top_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic                queue_mode_reg, queue_mode_next;
    logic [PTR_W-1:0]    rd_ptr_reg,     rd_ptr_next;
    logic [CNT_W-1:0]    remain_reg,     remain_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic                rsp_has_reg,    rsp_has_next;

    logic [PTR_W-1:0]    slot1;
    logic [PTR_W-1:0]    prev;
    logic [SUM_W-1:0]    tail_sum;
    logic [PTR_W-1:0]    tail;
    logic [63:0]         rd_ext;
    logic signed [VALUE_W-1:0] push_s;

    // Circular increment modulo DEPTH
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Neighbors of the top and the slot just past the bottom
    assign slot1    = ptr_inc(top_reg);
    assign prev     = (top_reg == '0) ? PTR_W'(DEPTH - 1) : top_reg - PTR_W'(1);
    assign tail_sum = SUM_W'(top_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(tail_sum);

    // Sign extension of a stored entry and of the pushed value
    assign rd_ext = 64'(signed'(mem_rd_data0));
    assign push_s = push_value;

    assign mem_rd_addr1 = slot1;

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        remain_next     = remain_reg;
        rsp_status_next = rsp_status_reg;
        rsp_has_next    = rsp_has_reg;
        queue_mode_next = cfg_wr_en ? cfg_wr_data : queue_mode_reg;

        in_ready     = 1'b0;
        rsp_load     = 1'b0;
        rsp          = '0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = top_reg;
        mem_wr_data  = mem_rd_data1;
        mem_rd_en    = 1'b0;
        mem_rd_addr0 = top_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    rsp_has_next    = 1'b0;
                    rsp_status_next = ST_OK;
                    case (cmd)
                        CMD_PUSH:
                        begin
                            state_next = S_RESP;
                            if (!value_valid)
                            begin
                                rsp_status_next = ST_BADARG;
                            end
                            else if (count_reg == CNT_W'(DEPTH))
                            begin
                                rsp_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = DATA_WIDTH'(push_s);
                                if (queue_mode_reg)
                                begin
                                    mem_wr_addr = tail;
                                end
                                else
                                begin
                                    mem_wr_addr = prev;
                                    top_next    = prev;
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                rd_ptr_next = slot1;
                                remain_next = count_reg;
                                state_next  = S_LIST;
                            end
                        end
                        CMD_PEEK:
                        begin
                            state_next = S_RESP;
                            if (count_reg == '0)
                            begin
                                rsp_status_next = ST_PEEK_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en    = 1'b1;
                                rsp_has_next = 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            state_next = S_RESP;
                            if (count_reg == '0)
                            begin
                                rsp_status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                top_next   = (count_reg == CNT_W'(1)) ? '0 : slot1;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                rsp_status_next = ST_SWAP_SHORT;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                state_next = S_SWAP1;
                            end
                        end
                        default:
                        begin
                            // unknown command: dropped
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (out_space)
                begin
                    rsp_load      = 1'b1;
                    rsp.value     = rsp_has_reg ? rd_ext[VALUE_W-1:0] : '0;
                    rsp.has_value = rsp_has_reg;
                    rsp.status    = rsp_status_reg;
                    rsp.last      = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_LIST:
            begin
                // one entry per cycle while out_space is high; the next read is issued as this one leaves
                if (out_space)
                begin
                    rsp_load      = 1'b1;
                    rsp.value     = rd_ext[VALUE_W-1:0];
                    rsp.has_value = 1'b1;
                    rsp.status    = ST_OK;
                    rsp.last      = (remain_reg == CNT_W'(1));
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_rd_en    = 1'b1;
                        mem_rd_addr0 = rd_ptr_reg;
                        rd_ptr_next  = ptr_inc(rd_ptr_reg);
                        remain_next  = remain_reg - CNT_W'(1);
                    end
                end
            end
            S_SWAP1:
            begin
                // second entry goes to the top
                mem_wr_en   = 1'b1;
                mem_wr_addr = top_reg;
                mem_wr_data = mem_rd_data1;
                state_next  = S_SWAP2;
            end
            S_SWAP2:
            begin
                // old top goes one below
                mem_wr_en       = 1'b1;
                mem_wr_addr     = slot1;
                mem_wr_data     = mem_rd_data0;
                rsp_status_next = ST_OK;
                rsp_has_next    = 1'b0;
                state_next      = S_RESP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            top_reg        <= '0;
            count_reg      <= '0;
            queue_mode_reg <= 1'b0;
            rd_ptr_reg     <= '0;
            remain_reg     <= '0;
            rsp_status_reg <= ST_OK;
            rsp_has_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            count_reg      <= count_next;
            queue_mode_reg <= queue_mode_next;
            rd_ptr_reg     <= rd_ptr_next;
            remain_reg     <= remain_next;
            rsp_status_reg <= rsp_status_next;
            rsp_has_reg    <= rsp_has_next;
        end
    end

endmodule

// File: hw/rtl/bounded_stack_queue_engine_unit.sv
// Top level of the bounded stack/queue engine: stream ports and output register.
//
//   channel   dir  handshake               payload
//   s_axis    in   s_axis_tvalid/tready    tdata: push_value; tuser: cmd, value_valid
//   m_axis    out  m_axis_tvalid/tready    tdata: read_value; tuser: has_value, status;
//                                          tlast: last
//   cfg       in   cfg_wr_en               cfg_wr_data: queue_mode
//
// Push, pop, peek and every error request: accept in S_IDLE, then the result enters
// the output register from S_RESP. Swap makes its two writes through the single store
// write port in S_SWAP1 and S_SWAP2. List reads in S_IDLE; S_LIST gives one entry
// per cycle while the output has space. Reset clears state, pointers, counts, mode,
// status and output valid, but not the store. A stalled output holds the sequencer
// in place; a new request is still accepted while the last result waits in out_reg.
module bounded_stack_queue_engine_unit #(
    parameter int DEPTH      = bsq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,   // queue_mode
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [bsq_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] push_value
    input  logic [3:0]                  s_axis_tuser,  // [2:0] cmd, [3] value_valid
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [bsq_pkg::VALUE_W-1:0] m_axis_tdata,  // [31:0] read_value
    output logic [3:0]                  m_axis_tuser,  // [0] has_value, [3:1] status
    output logic                        m_axis_tlast   // last
);
    import bsq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic                  out_valid_reg;
    rsp_t                  out_reg;
    logic                  out_space;
    logic                  rsp_load;
    rsp_t                  rsp;
    logic                  mem_wr_en;
    logic [PTR_W-1:0]      mem_wr_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [PTR_W-1:0]      mem_rd_addr0;
    logic [PTR_W-1:0]      mem_rd_addr1;
    logic [DATA_WIDTH-1:0] mem_rd_data0;
    logic [DATA_WIDTH-1:0] mem_rd_data1;

    assign out_space = !out_valid_reg || m_axis_tready;

    bsq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .cmd          (s_axis_tuser[2:0]),
        .push_value   (s_axis_tdata),
        .value_valid  (s_axis_tuser[3]),
        .out_space    (out_space),
        .rsp_load     (rsp_load),
        .rsp          (rsp),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr0 (mem_rd_addr0),
        .mem_rd_addr1 (mem_rd_addr1),
        .mem_rd_data0 (mem_rd_data0),
        .mem_rd_data1 (mem_rd_data1)
    );

    bsq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk      (clk),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .rd_en    (mem_rd_en),
        .rd_addr0 (mem_rd_addr0),
        .rd_addr1 (mem_rd_addr1),
        .rd_data0 (mem_rd_data0),
        .rd_data1 (mem_rd_data1)
    );

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            out_reg <= rsp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.value;
    assign m_axis_tuser  = {out_reg.status, out_reg.has_value};
    assign m_axis_tlast  = out_reg.last;

endmodule
